@@ src/chat_pkg.sv @@
// ============================================================================
// chat_pkg: callsign hash table shared definitions
// Types, codes and sizes used by the controller, the datapath and the top.
// ============================================================================
package chat_pkg;

    // The table size must be a power of two so that probe indexes wrap by masking.
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = 9;
    localparam int HASH_W        = 22;
    localparam int AGE_W         = 8;
    localparam int HEAD_W        = 64;
    localparam int TAIL_W        = 24;
    localparam int NAME_W        = HEAD_W + TAIL_W;
    localparam int NAME_CHARS    = NAME_W / 8;
    localparam int KEY_W         = 10;
    localparam int PROBE_MUL     = 23;
    localparam int PROD_W        = KEY_W + 5;
    localparam int STATUS_W      = 3;

    localparam logic [AGE_W-1:0] MAX_AGE_RST = 8'd10;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_SWEEP  = 2'd2;

    localparam logic [1:0] HW_22 = 2'd0;
    localparam logic [1:0] HW_12 = 2'd1;
    localparam logic [1:0] HW_10 = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SWEPT     = 3'd5;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [AGE_W-1:0]  age;
        logic [HEAD_W-1:0] head;
        logic [TAIL_W-1:0] tail;
    } t_entry;

    typedef struct packed {
        logic                load;
        logic                rd;
        logic                ins;
        logic                refresh;
        logic                free;
        logic                age_inc;
        logic                next;
        logic                capture;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       name_empty;
        logic       used;
        logic       add_match;
        logic       look_match;
        logic       age_over;
        logic       last_probe;
        logic       last_index;
        logic       out_busy;
    } t_sts;

endpackage

@@ src/chat_req_if.sv @@
// ============================================================================
// chat_req_if: request channel
// Carries one request item with a valid and ready handshake.
// ============================================================================
interface chat_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [chat_pkg::HASH_W-1:0] hash_value;
    logic [1:0]                 hash_width;
    logic [chat_pkg::HEAD_W-1:0] callsign_head;
    logic [chat_pkg::TAIL_W-1:0] callsign_tail;

    modport source (output valid, req_type, hash_value, hash_width, callsign_head,
                    callsign_tail, input ready);
    modport sink (input valid, req_type, hash_value, hash_width, callsign_head,
                  callsign_tail, output ready);
endinterface

@@ src/chat_rsp_if.sv @@
// ============================================================================
// chat_rsp_if: result channel
// Carries one result item with a valid and ready handshake.
// ============================================================================
interface chat_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [chat_pkg::STATUS_W-1:0] status;
    logic [chat_pkg::HEAD_W-1:0]   found_head;
    logic [chat_pkg::TAIL_W-1:0]   found_tail;
    logic [chat_pkg::CNT_W-1:0]    occupancy;

    modport source (output valid, status, found_head, found_tail, occupancy, input ready);
    modport sink (input valid, status, found_head, found_tail, occupancy, output ready);
endinterface

@@ src/chat_cfg_if.sv @@
// ============================================================================
// chat_cfg_if: configuration write channel
// Carries the max_age register value with a valid and ready handshake.
// ============================================================================
interface chat_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [chat_pkg::AGE_W-1:0] max_age;

    modport source (output valid, max_age, input ready);
    modport sink (input valid, max_age, output ready);
endinterface

@@ src/chat_ctrl.sv @@
// ============================================================================
// chat_ctrl: callsign hash table controller
// Sequences dispatch, probe reads, entry updates and result hand-off.
// ============================================================================
module chat_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  chat_pkg::t_sts i_sts,
    output chat_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [chat_pkg::STATUS_W-1:0] r_status;
    logic [chat_pkg::STATUS_W-1:0] n_status;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_status = r_status;
        o_cmd = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.req_type) inside
                    chat_pkg::REQ_ADD: begin
                        if (i_sts.name_empty) begin
                            n_status = chat_pkg::ST_DROPPED;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    chat_pkg::REQ_LOOKUP, chat_pkg::REQ_SWEEP: begin
                        n_state = S_RD;
                    end
                    default: begin
                        n_status = chat_pkg::ST_MISS;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = S_RD;
                unique case (i_sts.req_type)
                    chat_pkg::REQ_ADD: begin
                        if (!i_sts.used) begin
                            o_cmd.ins = 1'b1;
                            n_status = chat_pkg::ST_INSERTED;
                            n_state = S_DONE;
                        end else if (i_sts.add_match) begin
                            o_cmd.refresh = 1'b1;
                            n_status = chat_pkg::ST_REFRESHED;
                            n_state = S_DONE;
                        end else if (i_sts.last_probe) begin
                            n_status = chat_pkg::ST_DROPPED;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.next = 1'b1;
                        end
                    end
                    chat_pkg::REQ_LOOKUP: begin
                        if (!i_sts.used) begin
                            n_status = chat_pkg::ST_MISS;
                            n_state = S_DONE;
                        end else if (i_sts.look_match) begin
                            o_cmd.capture = 1'b1;
                            n_status = chat_pkg::ST_HIT;
                            n_state = S_DONE;
                        end else if (i_sts.last_probe) begin
                            n_status = chat_pkg::ST_MISS;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.next = 1'b1;
                        end
                    end
                    default: begin
                        if (i_sts.used) begin
                            o_cmd.free = i_sts.age_over;
                            o_cmd.age_inc = !i_sts.age_over;
                        end
                        if (i_sts.last_index) begin
                            n_status = chat_pkg::ST_SWEPT;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.next = 1'b1;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_status <= chat_pkg::ST_MISS;
        end else begin
            r_state <= n_state;
            r_status <= n_status;
        end
    end

endmodule

@@ src/chat_dpath.sv @@
// ============================================================================
// chat_dpath: callsign hash table datapath
// Entry memory, valid bits, probe index, occupancy count and result register.
// ============================================================================
module chat_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  chat_pkg::t_cmd                i_cmd,
    output chat_pkg::t_sts                o_sts,
    input  logic [chat_pkg::AGE_W-1:0]    i_max_age,
    input  logic [1:0]                    i_req_type,
    input  logic [chat_pkg::HASH_W-1:0]   i_hash_value,
    input  logic [1:0]                    i_hash_width,
    input  logic [chat_pkg::HEAD_W-1:0]   i_callsign_head,
    input  logic [chat_pkg::TAIL_W-1:0]   i_callsign_tail,
    input  logic                          i_rsp_ready,
    output logic                          o_rsp_valid,
    output logic [chat_pkg::STATUS_W-1:0] o_status,
    output logic [chat_pkg::HEAD_W-1:0]   o_found_head,
    output logic [chat_pkg::TAIL_W-1:0]   o_found_tail,
    output logic [chat_pkg::CNT_W-1:0]    o_occupancy
);

    // A callsign ends at its first zero character; later characters read as zero.
    function automatic logic [chat_pkg::NAME_W-1:0] norm_name(
        input logic [chat_pkg::NAME_W-1:0] name
    );
        logic [chat_pkg::NAME_W-1:0] res;
        logic                        alive;
        logic [7:0]                  c;
        res = '0;
        alive = 1'b1;
        for (int i = 0; i < chat_pkg::NAME_CHARS; i++) begin
            c = name[chat_pkg::NAME_W-1-8*i -: 8];
            if (c == 8'd0) begin
                alive = 1'b0;
            end
            res[chat_pkg::NAME_W-1-8*i -: 8] = alive ? c : 8'd0;
        end
        return res;
    endfunction

    chat_pkg::t_entry r_mem [chat_pkg::TABLE_ENTRIES];
    chat_pkg::t_entry r_rd;

    logic [chat_pkg::TABLE_ENTRIES-1:0] r_used;
    logic [chat_pkg::CNT_W-1:0]         r_count;
    logic [chat_pkg::IDX_W-1:0]         r_idx;
    logic [chat_pkg::IDX_W-1:0]         r_probe;
    logic [1:0]                         r_req_type;
    logic [chat_pkg::HASH_W-1:0]        r_hash;
    logic [1:0]                         r_hash_width;
    logic [chat_pkg::NAME_W-1:0]        r_name;
    logic [chat_pkg::HEAD_W-1:0]        r_found_head;
    logic [chat_pkg::TAIL_W-1:0]        r_found_tail;
    logic                               r_out_valid;
    logic [chat_pkg::STATUS_W-1:0]      r_out_status;
    logic [chat_pkg::HEAD_W-1:0]        r_out_head;
    logic [chat_pkg::TAIL_W-1:0]        r_out_tail;
    logic [chat_pkg::CNT_W-1:0]         r_out_occ;

    logic [chat_pkg::KEY_W-1:0]  s_key;
    logic [chat_pkg::PROD_W-1:0] s_prod;
    logic [chat_pkg::IDX_W-1:0]  s_start;
    logic [chat_pkg::IDX_W-1:0]  s_idx_inc;
    logic [chat_pkg::HASH_W-1:0] s_cmp_hash;
    logic                        s_we;
    chat_pkg::t_entry            s_wdata;

    always_comb begin
        case (i_hash_width)
            chat_pkg::HW_10: s_key = i_hash_value[9:0];
            chat_pkg::HW_12: s_key = i_hash_value[11:2];
            default:         s_key = i_hash_value[21:12];
        endcase
        if (i_req_type != chat_pkg::REQ_LOOKUP) begin
            s_key = i_hash_value[21:12];
        end
    end

    assign s_prod = chat_pkg::PROD_W'(s_key) * chat_pkg::PROD_W'(chat_pkg::PROBE_MUL);
    assign s_start = chat_pkg::IDX_W'(s_prod % chat_pkg::TABLE_ENTRIES);
    assign s_idx_inc = (r_idx == chat_pkg::IDX_W'(chat_pkg::TABLE_ENTRIES - 1)) ?
                       '0 : r_idx + 1'b1;

    always_comb begin
        case (r_hash_width)
            chat_pkg::HW_10: s_cmp_hash = {12'd0, r_rd.hash[21:12]};
            chat_pkg::HW_12: s_cmp_hash = {10'd0, r_rd.hash[21:10]};
            default:         s_cmp_hash = r_rd.hash;
        endcase
    end

    always_comb begin
        s_we = i_cmd.ins || i_cmd.refresh || i_cmd.age_inc;
        if (i_cmd.age_inc) begin
            s_wdata = r_rd;
            s_wdata.age = r_rd.age + 1'b1;
        end else begin
            s_wdata.hash = r_hash;
            s_wdata.age = '0;
            s_wdata.head = r_name[chat_pkg::NAME_W-1 -: chat_pkg::HEAD_W];
            s_wdata.tail = r_name[chat_pkg::TAIL_W-1:0];
        end
    end

    always_comb begin
        o_sts.req_type = r_req_type;
        o_sts.name_empty = (r_name[chat_pkg::NAME_W-1 -: 8] == 8'd0);
        o_sts.used = r_used[r_idx];
        o_sts.add_match = (r_rd.hash == r_hash) &&
                          (r_rd.head == r_name[chat_pkg::NAME_W-1 -: chat_pkg::HEAD_W]) &&
                          (r_rd.tail == r_name[chat_pkg::TAIL_W-1:0]);
        o_sts.look_match = (s_cmp_hash == r_hash);
        o_sts.age_over = (r_rd.age > i_max_age);
        o_sts.last_probe = (r_probe == chat_pkg::IDX_W'(chat_pkg::TABLE_ENTRIES - 1));
        o_sts.last_index = (r_idx == chat_pkg::IDX_W'(chat_pkg::TABLE_ENTRIES - 1));
        o_sts.out_busy = r_out_valid && !i_rsp_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx];
        end
        if (s_we) begin
            r_mem[r_idx] <= s_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins) begin
                r_used[r_idx] <= 1'b1;
                r_count <= r_count + 1'b1;
            end else if (i_cmd.free) begin
                r_used[r_idx] <= 1'b0;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_hash <= i_hash_value;
            r_hash_width <= i_hash_width;
            r_name <= norm_name({i_callsign_head, i_callsign_tail});
            r_idx <= (i_req_type == chat_pkg::REQ_SWEEP) ? '0 : s_start;
            r_probe <= '0;
            r_found_head <= '0;
            r_found_tail <= '0;
        end else if (i_cmd.next) begin
            r_idx <= s_idx_inc;
            r_probe <= r_probe + 1'b1;
        end
        if (i_cmd.capture) begin
            r_found_head <= r_rd.head;
            r_found_tail <= r_rd.tail;
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.status;
            r_out_head <= r_found_head;
            r_out_tail <= r_found_tail;
            r_out_occ <= r_count;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_found_head = r_out_head;
    assign o_found_tail = r_out_tail;
    assign o_occupancy = r_out_occ;

endmodule

@@ src/callsign_hash_table_ageing_unit.sv @@
// ============================================================================
// callsign_hash_table_ageing_unit: callsign hash table with ageing
// Open-addressed callsign table with add, lookup and age sweep requests.
// ============================================================================
// Each request item passes dispatch, a probe loop and result hand-off; an add or a
// lookup takes 0 to 256 probes and a sweep takes 256, each one a read of the single
// entry memory port (S_RD) followed by a check-and-write state (S_CHK).
// One item at a time: a new item is taken only after the last result is loaded out.
// Reset clears all valid bits and the occupancy, sets max_age to 10, and needs no
// clearing pass; the block takes items right after reset.
module callsign_hash_table_ageing_unit (
    input logic         i_clk,
    input logic         i_rst_n,
    chat_req_if.sink    i_req,
    chat_rsp_if.source  o_rsp,
    chat_cfg_if.sink    i_cfg
);

    chat_pkg::t_cmd              s_cmd;
    chat_pkg::t_sts              s_sts;
    logic [chat_pkg::AGE_W-1:0]  r_max_age;
    logic                        s_req_ready;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = s_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= chat_pkg::MAX_AGE_RST;
        end else if (i_cfg.valid) begin
            r_max_age <= i_cfg.max_age;
        end
    end

    chat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (s_req_ready),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd)
    );

    chat_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_sts           (s_sts),
        .i_max_age       (r_max_age),
        .i_req_type      (i_req.req_type),
        .i_hash_value    (i_req.hash_value),
        .i_hash_width    (i_req.hash_width),
        .i_callsign_head (i_req.callsign_head),
        .i_callsign_tail (i_req.callsign_tail),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_found_head    (o_rsp.found_head),
        .o_found_tail    (o_rsp.found_tail),
        .o_occupancy     (o_rsp.occupancy)
    );

endmodule

@@ dv/chat_table_checker.sv @@
// ============================================================================
// chat_table_checker: callsign table scoreboard
// Keeps a mirror of the callsign table, updates it on every accepted request
// item, and compares each result item field by field with the oldest
// predicted one.
// ============================================================================
module chat_table_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    chat_req_if  i_req,
    chat_rsp_if  i_rsp,
    chat_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import chat_pkg::*;

    localparam int KEY_SHIFT    = HASH_W - KEY_W;
    localparam int SHIFT_FOR_12 = HASH_W - 12;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HEAD_W-1:0]   head;
        logic [TAIL_W-1:0]   tail;
        logic [CNT_W-1:0]    occupancy;
    } t_reply;

    logic [AGE_W-1:0]  age_limit;
    logic              slot_used [TABLE_ENTRIES];
    logic [HASH_W-1:0] slot_hash [TABLE_ENTRIES];
    logic [AGE_W-1:0]  slot_age  [TABLE_ENTRIES];
    logic [NAME_W-1:0] slot_name [TABLE_ENTRIES];
    int unsigned       slot_count;
    t_reply            expected_replies [$];
    int                fail_count;

    function automatic logic [NAME_W-1:0] trim_callsign(input logic [NAME_W-1:0] name);
        logic [NAME_W-1:0] trimmed;
        bit                ended;
        int                i;
        trimmed = '0;
        ended   = 1'b0;
        for (i = 0; i < NAME_CHARS; i++) begin
            if (name[NAME_W-1-8*i -: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                trimmed[NAME_W-1-8*i -: 8] = name[NAME_W-1-8*i -: 8];
            end
        end
        return trimmed;
    endfunction

    function automatic int unsigned probe_start(input logic [KEY_W-1:0] key);
        return (int'(key) * PROBE_MUL) % TABLE_ENTRIES;
    endfunction

    function automatic t_reply apply_request(input logic [1:0] kind,
                                             input logic [HASH_W-1:0] hash,
                                             input logic [1:0] width,
                                             input logic [NAME_W-1:0] raw_name);
        t_reply            reply;
        logic [NAME_W-1:0] name;
        int unsigned       idx;
        int unsigned       shift;
        int                probe;
        bit                done;
        reply = '0;
        done  = 1'b0;
        case (kind)
            REQ_ADD: begin
                name         = trim_callsign(raw_name);
                reply.status = ST_DROPPED;
                if (name[NAME_W-1 -: 8] != 8'd0) begin
                    idx = probe_start(hash[HASH_W-1 -: KEY_W]);
                    for (probe = 0; probe < TABLE_ENTRIES && !done; probe++) begin
                        if (!slot_used[idx]) begin
                            slot_used[idx] = 1'b1;
                            slot_hash[idx] = hash;
                            slot_age[idx]  = '0;
                            slot_name[idx] = name;
                            slot_count++;
                            reply.status = ST_INSERTED;
                            done = 1'b1;
                        end else if (slot_hash[idx] == hash && slot_name[idx] == name) begin
                            slot_age[idx] = '0;
                            reply.status  = ST_REFRESHED;
                            done = 1'b1;
                        end else begin
                            idx = (idx + 1) % TABLE_ENTRIES;
                        end
                    end
                end
            end
            REQ_LOOKUP: begin
                shift = (width == HW_10) ? KEY_SHIFT : (width == HW_12) ? SHIFT_FOR_12 : 0;
                idx   = probe_start(KEY_W'(hash >> (KEY_SHIFT - shift)));
                reply.status = ST_MISS;
                for (probe = 0; probe < TABLE_ENTRIES && !done; probe++) begin
                    if (!slot_used[idx]) begin
                        done = 1'b1;
                    end else if ((slot_hash[idx] >> shift) == hash) begin
                        reply.status = ST_HIT;
                        reply.head   = slot_name[idx][NAME_W-1 -: HEAD_W];
                        reply.tail   = slot_name[idx][TAIL_W-1:0];
                        done = 1'b1;
                    end else begin
                        idx = (idx + 1) % TABLE_ENTRIES;
                    end
                end
            end
            REQ_SWEEP: begin
                for (idx = 0; idx < TABLE_ENTRIES; idx++) begin
                    if (slot_used[idx]) begin
                        if (slot_age[idx] > age_limit) begin
                            slot_used[idx] = 1'b0;
                            slot_hash[idx] = '0;
                            slot_age[idx]  = '0;
                            slot_name[idx] = '0;
                            slot_count--;
                        end else begin
                            slot_age[idx] = slot_age[idx] + 1'b1;
                        end
                    end
                end
                reply.status = ST_SWEPT;
            end
            default: begin
                reply.status = ST_MISS;
            end
        endcase
        reply.occupancy = slot_count[CNT_W-1:0];
        return reply;
    endfunction

    task automatic note_failure(input string what, input t_reply want, input t_reply got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected status %0d head %h tail %h occupancy %0d,",
                     $realtime, what, want.status, want.head, want.tail, want.occupancy);
            $display("    got status %0d head %h tail %h occupancy %0d",
                     got.status, got.head, got.tail, got.occupancy);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            age_limit  = MAX_AGE_RST;
            slot_count = 0;
            fail_count = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_hash[i] = '0;
                slot_age[i]  = '0;
                slot_name[i] = '0;
            end
            expected_replies.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                age_limit = i_cfg.max_age;
            end
            if (i_req.valid && i_req.ready) begin
                expected_replies.push_back(apply_request(i_req.req_type, i_req.hash_value,
                                                         i_req.hash_width,
                                                         {i_req.callsign_head,
                                                          i_req.callsign_tail}));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = {i_rsp.status, i_rsp.found_head, i_rsp.found_tail, i_rsp.occupancy};
                if (expected_replies.size() == 0) begin
                    note_failure("unexpected result item", '0, got);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status != want.status || got.head != want.head ||
                        got.tail != want.tail || got.occupancy != want.occupancy) begin
                        note_failure("result mismatch", want, got);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_replies.size();
    end

endmodule

@@ dv/callsign_hash_table_ageing_unit_tb.sv @@
// ============================================================================
// callsign_hash_table_ageing_unit_tb: callsign table testbench
// Drives directed and random add, lookup and sweep requests under several
// max_age settings with random idling on both channels, fills the table past
// capacity and wraps the entry ages; the checker scores every result item.
// ============================================================================
module callsign_hash_table_ageing_unit_tb;
    import chat_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 600;
    localparam int TIMEOUT_CYCLES = 5_000_000;
    localparam int POOL_SIZE      = 48;
    localparam int KEY_SHIFT      = HASH_W - KEY_W;
    localparam int SHIFT_FOR_12   = HASH_W - 12;

    localparam logic [1:0] REQ_IDLE = 2'd3;
    localparam logic [1:0] HW_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   calm_source;
    bit   calm_sink;
    int   kind_count [4];
    int   cfg_writes;

    logic [HASH_W-1:0] pool_hash [POOL_SIZE];
    logic [NAME_W-1:0] pool_name [POOL_SIZE];

    chat_req_if req_ch ();
    chat_rsp_if rsp_ch ();
    chat_cfg_if cfg_ch ();

    callsign_hash_table_ageing_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    chat_table_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [NAME_W-1:0] noise_name();
        return NAME_W'({$urandom, $urandom, $urandom});
    endfunction

    function automatic logic [NAME_W-1:0] make_callsign();
        logic [NAME_W-1:0] name;
        logic [7:0]        ch;
        int                len;
        int                r;
        int                i;
        name = '0;
        len  = $urandom_range(1, NAME_CHARS);
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                ch = 8'(8'h41 + $urandom_range(0, 25));
            end else if (r < 92) begin
                ch = 8'(8'h30 + $urandom_range(0, 9));
            end else if (r < 95) begin
                ch = 8'h2F;
            end else begin
                ch = 8'($urandom_range(1, 255));
            end
            name[NAME_W-1-8*i -: 8] = ch;
        end
        return name;
    endfunction

    // Junk after the terminating zero must be ignored by the table.
    function automatic logic [NAME_W-1:0] add_junk(input logic [NAME_W-1:0] name);
        logic [NAME_W-1:0] junked;
        bit                ended;
        int                i;
        junked = name;
        ended  = 1'b0;
        for (i = 0; i < NAME_CHARS; i++) begin
            if (ended) begin
                junked[NAME_W-1-8*i -: 8] = 8'($urandom);
            end else if (name[NAME_W-1-8*i -: 8] == 8'd0) begin
                ended = 1'b1;
            end
        end
        return junked;
    endfunction

    function automatic void refill_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++) begin
            pool_name[i] = make_callsign();
            if (i > 0 && $urandom_range(0, 99) < 15) begin
                pool_hash[i] = pool_hash[i-1];
            end else begin
                pool_hash[i] = HASH_W'($urandom);
                if ($urandom_range(0, 1) == 0) begin
                    pool_hash[i][HASH_W-1 -: KEY_W] = KEY_W'($urandom_range(0, 3));
                end
            end
        end
    endfunction

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            int stall;
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
                stall = 0;
            end else if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end else begin
                rsp_ch.ready <= 1'b1;
                stall = calm_sink ? 0 : idle_gap();
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [HASH_W-1:0] hash,
                             input logic [1:0] width, input logic [NAME_W-1:0] name);
        int gap;
        req_ch.req_type      <= kind;
        req_ch.hash_value    <= hash;
        req_ch.hash_width    <= width;
        req_ch.callsign_head <= name[NAME_W-1 -: HEAD_W];
        req_ch.callsign_tail <= name[TAIL_W-1:0];
        req_ch.valid         <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        kind_count[kind]++;
        gap = calm_source ? 0 : idle_gap();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_pool_entry(input int p);
        send_item(REQ_ADD, pool_hash[p], 2'($urandom),
                  ($urandom_range(0, 99) < 30) ? add_junk(pool_name[p]) : pool_name[p]);
    endtask

    task automatic look_up_pool_entry(input int p);
        logic [1:0]        width;
        logic [HASH_W-1:0] key;
        width = 2'($urandom_range(0, 2));
        case (width)
            HW_12: key = pool_hash[p] >> SHIFT_FOR_12;
            HW_10: key = pool_hash[p] >> KEY_SHIFT;
            default: key = pool_hash[p];
        endcase
        if (width == HW_22 && $urandom_range(0, 3) == 0) begin
            width = HW_SPARE;
        end
        send_item(REQ_LOOKUP, key, width, noise_name());
    endtask

    task automatic send_sweep();
        send_item(REQ_SWEEP, HASH_W'($urandom), 2'($urandom), noise_name());
    endtask

    task automatic wait_until_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_max_age(input logic [AGE_W-1:0] value);
        wait_until_idle();
        cfg_ch.max_age <= value;
        cfg_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_mix(input int count);
        logic [NAME_W-1:0] name;
        int                r;
        int                p;
        int                j;
        refill_pool();
        for (j = 0; j < count; j++) begin
            if (j % 64 == 0) begin
                calm_source = ($urandom_range(0, 3) == 0);
                calm_sink   = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 149) == 0) begin
                wait_until_idle();
            end
            r = $urandom_range(0, 99);
            p = $urandom_range(0, POOL_SIZE - 1);
            if (r < 40) begin
                add_pool_entry(p);
            end else if (r < 70) begin
                look_up_pool_entry(p);
            end else if (r < 78) begin
                send_item(REQ_LOOKUP, HASH_W'($urandom), 2'($urandom), noise_name());
            end else if (r < 84) begin
                send_sweep();
            end else if (r < 88) begin
                send_item(REQ_IDLE, HASH_W'($urandom), 2'($urandom), noise_name());
            end else if (r < 92) begin
                name = noise_name();
                if ($urandom_range(0, 3) == 0) begin
                    name[NAME_W-1 -: 8] = 8'd0;
                end
                send_item(REQ_ADD, HASH_W'($urandom), 2'($urandom), name);
            end else begin
                send_item(REQ_ADD, HASH_W'($urandom), 2'($urandom), add_junk(make_callsign()));
            end
        end
    endtask

    initial begin
        int r;
        int i;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_ADD;
        req_ch.hash_value    = '0;
        req_ch.hash_width    = HW_22;
        req_ch.callsign_head = '0;
        req_ch.callsign_tail = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.max_age       = '0;
        calm_source          = 1'b0;
        calm_sink            = 1'b0;
        cfg_writes           = 0;
        kind_count           = '{default: 0};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(REQ_LOOKUP, 22'h0, HW_22, '0);
        send_sweep();
        send_item(REQ_ADD, 22'h3FFFFF, HW_22, {64'h00_4B_31_41_42_43_00_00, 24'hABCDEF});
        send_item(REQ_ADD, 22'h3FFFFF, HW_SPARE, {64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF});
        send_item(REQ_ADD, 22'h0, HW_22, {64'h4B_31_41_42_43_00_5A_5A, 24'h5A5A5A});
        send_item(REQ_ADD, 22'h0, HW_22, {64'h4B_31_41_42_43_00_11_11, 24'h000000});
        send_item(REQ_ADD, 22'h000ABC, HW_22, {64'h57_31_41_57_00_00_00_00, 24'h0});
        send_item(REQ_LOOKUP, 22'h0, HW_22, noise_name());
        send_item(REQ_LOOKUP, 22'h000ABC, HW_22, noise_name());
        send_item(REQ_LOOKUP, 22'h000FFF, HW_12, noise_name());
        send_item(REQ_LOOKUP, 22'h0003FF, HW_10, noise_name());
        send_item(REQ_LOOKUP, 22'h3FFFFF, HW_SPARE, noise_name());
        send_item(REQ_LOOKUP, 22'h3FFFFF, HW_10, noise_name());
        send_item(REQ_IDLE, 22'h3FFFFF, HW_SPARE, {NAME_W{1'b1}});
        send_item(REQ_ADD, 22'h3FFFFF, HW_22, {64'h56_4B_32_58_59_5A_31_32, 24'h333435});
        send_item(REQ_LOOKUP, 22'h123456, HW_22, noise_name());
        send_sweep();
        send_item(REQ_LOOKUP, 22'h3FFFFF, HW_22, noise_name());

        write_max_age(8'd3);
        run_mix(400);

        // Fill the table past capacity so that adds drop and lookups run a full lap.
        write_max_age(8'hFF);
        refill_pool();
        for (i = 0; i < 20; i++) begin
            add_pool_entry(i);
        end
        for (i = 0; i < 300; i++) begin
            r = $urandom_range(0, 99);
            if (r < 88) begin
                send_item(REQ_ADD, HASH_W'($urandom), 2'($urandom), make_callsign());
            end else if (r < 94) begin
                add_pool_entry($urandom_range(0, 19));
            end else begin
                look_up_pool_entry($urandom_range(0, POOL_SIZE - 1));
            end
        end

        write_max_age(8'd0);
        send_sweep();
        send_sweep();
        run_mix(200);

        // Enough sweeps with the largest max_age to wrap every age at least once.
        write_max_age(8'hFF);
        refill_pool();
        for (i = 0; i < 8; i++) begin
            add_pool_entry(i);
        end
        for (i = 0; i < 258; i++) begin
            if (i % 32 == 31) begin
                look_up_pool_entry($urandom_range(0, 7));
            end
            send_sweep();
        end

        write_max_age(8'($urandom_range(1, 254)));
        run_mix(180);

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d adds, %0d lookups, %0d age sweeps and %0d no-op requests",
                 kind_count[REQ_ADD], kind_count[REQ_LOOKUP], kind_count[REQ_SWEEP],
                 kind_count[REQ_IDLE]);
        $display("over %0d max_age settings, including a full table and an age wrap.",
                 cfg_writes + 1);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d results outstanding.", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule
